// File: rtl/core/ps2mpt_pkg.sv
package ps2mpt_pkg;

  localparam int COUNTER_WIDTH = 32;

  // command queue between the byte front end and the execute pipeline
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_BTN    = 3'd4;

  localparam logic [7:0] SCALE_PCT [5] = '{8'd40, 8'd70, 8'd100, 8'd130, 8'd170};
  localparam logic [7:0] PCT_UNITY     = 8'd100;
  localparam logic [7:0] ROUND_HALF    = 8'd50;
  // floor(p / 100) == (p * RECIP_100) >> RECIP_SHIFT for every p below 91180
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          RECIP_SHIFT = 23;

  localparam logic [7:0] B0_SYNC     = 8'h08;
  localparam logic [7:0] B0_OVERFLOW = 8'hC0;

  localparam logic [14:0] RST_POS_X = 15'd160;
  localparam logic [14:0] RST_POS_Y = 15'd100;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,  // byte counted only
    CMD_PACKET = 2'd1,  // completed packet without overflow
    CMD_SETPOS = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [7:0]         b3;
    logic signed [15:0] set_x;
    logic signed [15:0] set_y;
  } cmd_t;

  typedef struct packed {
    logic [14:0] bound_width;
    logic [14:0] bound_height;
    logic [2:0]  sensitivity;
    logic        four_byte;
    logic        extra_buttons;
  } cfg_t;

endpackage

// File: rtl/core/ps2mpt_front.sv
module ps2mpt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic [15:0]       set_x_i,
  input  logic [15:0]       set_y_i,
  input  ps2mpt_pkg::cfg_t  cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output ps2mpt_pkg::cmd_t  cmd_o
);
  import ps2mpt_pkg::*;

  logic [1:0] pos_q, pos_d;
  logic [7:0] pb0_q, pb1_q, pb2_q;
  logic       acc;
  logic [1:0] last;
  logic       skip;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;
  assign push_o     = acc;
  assign last       = cfg_i.four_byte ? 2'd3 : 2'd2;
  assign skip       = (pos_q == 2'd0) && ((data_byte_i & B0_SYNC) == 8'h00);

  always_comb begin
    pos_d       = pos_q;
    cmd_o.kind  = CMD_BYTE;
    cmd_o.b0    = pb0_q;
    cmd_o.b1    = pb1_q;
    cmd_o.b2    = (pos_q == 2'd2) ? data_byte_i : pb2_q;
    cmd_o.b3    = data_byte_i;
    cmd_o.set_x = signed'(set_x_i);
    cmd_o.set_y = signed'(set_y_i);
    if (req_type_i) begin
      cmd_o.kind = CMD_SETPOS;
    end else if (!skip) begin
      if (pos_q >= last) begin
        pos_d = 2'd0;
        if ((pb0_q & B0_OVERFLOW) == 8'h00) begin
          cmd_o.kind = CMD_PACKET;
        end
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else if (acc) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !req_type_i && !skip) begin
      unique case (pos_q)
        2'd0:    pb0_q <= data_byte_i;
        2'd1:    pb1_q <= data_byte_i;
        2'd2:    pb2_q <= data_byte_i;
        default: ;
      endcase
    end
  end

  a_sync_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !req_type_i && skip |=> pos_q == 2'd0)
    else $error("unsynced byte advanced packet position");

  a_setpos_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req_type_i |=> $stable(pos_q))
    else $error("position request disturbed packet assembly");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !push_o)
    else $error("command pushed into full queue");

endmodule

// File: rtl/core/ps2mpt_fifo.sv
module ps2mpt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ps2mpt_pkg::cmd_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ps2mpt_pkg::cmd_t  data_o
);
  import ps2mpt_pkg::*;

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
    ptr_inc = (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !push_i && valid_o |=> count_q == $past(count_q) - FIFO_CW'(1))
    else $error("queue count lost a pop");

endmodule

// File: rtl/core/ps2mpt_back.sv
module ps2mpt_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ps2mpt_pkg::cfg_t       cfg_i,
  input  logic                   cmd_valid_i,
  input  ps2mpt_pkg::cmd_t       cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [14:0]            cursor_x_o,
  output logic [14:0]            cursor_y_o,
  output logic signed [9:0]      last_dx_o,
  output logic signed [9:0]      last_dy_o,
  output logic signed [15:0]     wheel_total_o,
  output logic [5:0]             button_bits_o,
  output logic [31:0]            packet_count_o,
  output logic [31:0]            rx_bytes_o,
  output logic                   packet_done_o
);
  import ps2mpt_pkg::*;

  // stage 1: scale products
  logic               s1_vld_q;
  cmd_kind_e          s1_kind_q;
  logic [7:0]         s1_b0_q, s1_b3_q;
  logic signed [15:0] s1_sx_q, s1_sy_q;
  logic signed [8:0]  s1_dx_q, s1_dy_q;
  logic [15:0]        s1_px_q, s1_py_q;
  logic               s1_unity_q;
  // stage 2: scaled deltas
  logic               s2_vld_q;
  cmd_kind_e          s2_kind_q;
  logic [7:0]         s2_b0_q, s2_b3_q;
  logic signed [15:0] s2_sx_q, s2_sy_q;
  logic signed [9:0]  s2_dx_q, s2_dy_q;
  // stage 3: architectural state, doubles as the output register
  logic                     out_vld_q, done_q;
  logic [14:0]              pos_x_q, pos_y_q;
  logic signed [9:0]        delta_x_q, delta_y_q;
  logic [15:0]              wheel_q;
  logic [5:0]               buttons_q;
  logic [COUNTER_WIDTH-1:0] packets_q, bytes_q;

  logic              advance;
  logic [2:0]        sel;
  logic [7:0]        pct;
  logic signed [8:0] dx9, dy9;

  assign advance   = !out_vld_q || out_ready_i;
  assign cmd_pop_o = advance && cmd_valid_i;

  always_comb begin
    priority if (cfg_i.sensitivity == 3'd0) begin
      sel = 3'd0;
    end else if (cfg_i.sensitivity > 3'd5) begin
      sel = 3'd4;
    end else begin
      sel = cfg_i.sensitivity - 3'd1;
    end
  end
  assign pct = SCALE_PCT[sel];
  assign dx9 = signed'({cmd_i.b0[4], cmd_i.b1});
  assign dy9 = signed'({cmd_i.b0[5], cmd_i.b2});

  function automatic logic [15:0] scale_prod(input logic signed [8:0] v,
                                             input logic [7:0] p);
    logic [8:0] mag;
    mag = v[8] ? 9'(-v) : 9'(v);
    scale_prod = 16'(17'(mag) * 17'(p) + 17'(ROUND_HALF));
  endfunction

  function automatic logic signed [9:0] scale_fin(input logic signed [8:0] v,
                                                  input logic [15:0] prod,
                                                  input logic unity);
    logic [32:0] m;
    logic [9:0]  s;
    m = 33'(prod) * 33'(RECIP_100);
    s = m[RECIP_SHIFT+9:RECIP_SHIFT];
    if (s == 10'd0) s = 10'd1;
    if (v == 9'sd0) begin
      scale_fin = 10'sd0;
    end else if (unity) begin
      scale_fin = 10'(v);
    end else begin
      scale_fin = v[8] ? -signed'(s) : signed'(s);
    end
  endfunction

  function automatic logic [14:0] clamp_axis(input logic signed [17:0] v,
                                             input logic [14:0] bound);
    logic [14:0] top;
    top = (bound == 15'd0) ? 15'd0 : bound - 15'd1;
    if (v < 18'sd0) begin
      clamp_axis = 15'd0;
    end else if (v > signed'({3'b000, top})) begin
      clamp_axis = top;
    end else begin
      clamp_axis = v[14:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q  <= cmd_valid_i;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_kind_q  <= cmd_i.kind;
      s1_b0_q    <= cmd_i.b0;
      s1_b3_q    <= cmd_i.b3;
      s1_sx_q    <= cmd_i.set_x;
      s1_sy_q    <= cmd_i.set_y;
      s1_dx_q    <= dx9;
      s1_dy_q    <= dy9;
      s1_px_q    <= scale_prod(dx9, pct);
      s1_py_q    <= scale_prod(dy9, pct);
      s1_unity_q <= (pct == PCT_UNITY);
      s2_kind_q  <= s1_kind_q;
      s2_b0_q    <= s1_b0_q;
      s2_b3_q    <= s1_b3_q;
      s2_sx_q    <= s1_sx_q;
      s2_sy_q    <= s1_sy_q;
      s2_dx_q    <= scale_fin(s1_dx_q, s1_px_q, s1_unity_q);
      s2_dy_q    <= scale_fin(s1_dy_q, s1_py_q, s1_unity_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      pos_x_q   <= RST_POS_X;
      pos_y_q   <= RST_POS_Y;
      delta_x_q <= 10'sd0;
      delta_y_q <= 10'sd0;
      wheel_q   <= 16'd0;
      buttons_q <= 6'd0;
      packets_q <= '0;
      bytes_q   <= '0;
    end else if (advance && s2_vld_q) begin
      done_q <= (s2_kind_q == CMD_PACKET);
      unique case (s2_kind_q)
        CMD_BYTE: begin
          bytes_q <= bytes_q + COUNTER_WIDTH'(1);
        end
        CMD_PACKET: begin
          bytes_q   <= bytes_q + COUNTER_WIDTH'(1);
          packets_q <= packets_q + COUNTER_WIDTH'(1);
          delta_x_q <= s2_dx_q;
          delta_y_q <= s2_dy_q;
          pos_x_q   <= clamp_axis(18'(signed'({1'b0, pos_x_q})) + 18'(s2_dx_q),
                                  cfg_i.bound_width);
          pos_y_q   <= clamp_axis(18'(signed'({1'b0, pos_y_q})) - 18'(s2_dy_q),
                                  cfg_i.bound_height);
          if (cfg_i.four_byte) begin
            wheel_q <= wheel_q + {{12{s2_b3_q[3]}}, s2_b3_q[3:0]};
          end
          buttons_q <= {(cfg_i.four_byte && cfg_i.extra_buttons) ? s2_b3_q[5:4] : 2'b00,
                        1'b0, s2_b0_q[2:0]};
        end
        CMD_SETPOS: begin
          pos_x_q <= clamp_axis(18'(s2_sx_q), cfg_i.bound_width);
          pos_y_q <= clamp_axis(18'(s2_sy_q), cfg_i.bound_height);
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_vld_q;
  assign cursor_x_o     = pos_x_q;
  assign cursor_y_o     = pos_y_q;
  assign last_dx_o      = delta_x_q;
  assign last_dy_o      = delta_y_q;
  assign wheel_total_o  = signed'(wheel_q);
  assign button_bits_o  = buttons_q;
  assign packet_count_o = 32'(packets_q);
  assign rx_bytes_o     = 32'(bytes_q);
  assign packet_done_o  = done_q;

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> $stable(s1_vld_q) && $stable(s2_vld_q))
    else $error("pipeline moved while output stalled");

  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |-> !cmd_pop_o)
    else $error("command popped while output stalled");

  a_done_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s2_vld_q && s2_kind_q == CMD_PACKET |=>
      packets_q == $past(packets_q) + COUNTER_WIDTH'(1) && done_q)
    else $error("packet completed without count");

endmodule

// File: rtl/core/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker.
// Input stream: one request per beat. tuser = 0 carries a raw aux byte in
// tdata[7:0]; tuser = 1 places the cursor at tdata[23:8] / tdata[39:24]
// (signed, clamped to the bounds). Every request returns exactly one result
// beat with the full tracker state after it; tuser of the result flags a
// completed, accepted packet.
// Config channel: cfg_addr_i picks bound_width, bound_height, sensitivity,
// four_byte_packets, extra_buttons_mode (0..4); always ready, write only
// while no request is outstanding.
// Throughput: one request per cycle unless stalled (see Stall). The front end
// assembles packets and pushes a classified command into a two-entry queue;
// the back end is a three-stage execute pipeline (scale multiply, reciprocal
// divide, state update), the last stage doubling as the output register.
// Path: a taken request is written into the queue, then passes the three execute stages.
// Stall: when the receiver holds tready low on a valid result the pipeline freezes,
// the queue fills and s_axis_tready_o drops once it holds two commands.
// Reset: cursor at 160/100, counters, deltas, wheel and buttons cleared,
// bounds 320 x 200, sensitivity 3, three-byte packets.
module ps2_mouse_packet_tracker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [39:0]                          s_axis_tdata_i,  // data_byte, set_x, set_y
  input  logic [0:0]                           s_axis_tuser_i,  // req_type
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // cursor_x, cursor_y, last_dx, last_dy, wheel_total, button_bits,
  // packet_count, rx_bytes
  output logic [135:0]                         m_axis_tdata_o,
  output logic [0:0]                           m_axis_tuser_o,  // packet_done
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ps2mpt_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [14:0]                          cfg_data_i
);
  import ps2mpt_pkg::*;

  cfg_t cfg_q;
  cmd_t front_cmd, fifo_cmd;
  logic push, full, pop, fifo_valid;

  logic [14:0]        cursor_x, cursor_y;
  logic signed [9:0]  last_dx, last_dy;
  logic signed [15:0] wheel_total;
  logic [5:0]         button_bits;
  logic [31:0]        packet_count, rx_bytes;
  logic               packet_done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bound_width   <= 15'd320;
      cfg_q.bound_height  <= 15'd200;
      cfg_q.sensitivity   <= 3'd3;
      cfg_q.four_byte     <= 1'b0;
      cfg_q.extra_buttons <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_BOUND_WIDTH:  cfg_q.bound_width   <= cfg_data_i;
        CFG_BOUND_HEIGHT: cfg_q.bound_height  <= cfg_data_i;
        CFG_SENSITIVITY:  cfg_q.sensitivity   <= cfg_data_i[2:0];
        CFG_FOUR_BYTE:    cfg_q.four_byte     <= cfg_data_i[0];
        CFG_EXTRA_BTN:    cfg_q.extra_buttons <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ps2mpt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i[0]),
    .data_byte_i (s_axis_tdata_i[7:0]),
    .set_x_i     (s_axis_tdata_i[23:8]),
    .set_y_i     (s_axis_tdata_i[39:24]),
    .cfg_i       (cfg_q),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  ps2mpt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_cmd)
  );

  ps2mpt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_valid_i    (fifo_valid),
    .cmd_i          (fifo_cmd),
    .cmd_pop_o      (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .cursor_x_o     (cursor_x),
    .cursor_y_o     (cursor_y),
    .last_dx_o      (last_dx),
    .last_dy_o      (last_dy),
    .wheel_total_o  (wheel_total),
    .button_bits_o  (button_bits),
    .packet_count_o (packet_count),
    .rx_bytes_o     (rx_bytes),
    .packet_done_o  (packet_done)
  );

  assign m_axis_tdata_o = {rx_bytes, packet_count, button_bits, wheel_total,
                           last_dy, last_dx, cursor_y, cursor_x};
  assign m_axis_tuser_o = packet_done;

endmodule
